// ===== rtl/ilir_pkg.sv =====
`timescale 1ns / 1ps

package ilir_pkg;

    localparam int DEPTH    = 64;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = 7;
    localparam int CNT_W    = 7;
    localparam int POS_W    = $clog2(DEPTH);
    localparam int GRP_SIZE = 8;
    localparam int GRP_CNT  = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int SHRINK_STEPS = $clog2(DEPTH);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_SET    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic               ins;
        logic               rem;
        logic               wr;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

// ===== rtl/indexed_list_insert_remove_core.sv =====
`timescale 1ns / 1ps

// Ordered list of up to 64 values kept in a chain of cells, one entry per
// cell. Each transfer carries one operation (insert, remove, get, set);
// insert and remove shift every entry above the index by one cell all
// at once, and the entry at the index is read back through an
// OR tree registered after its first level of eight cells. An item passes
// through accept, execute and respond, and the block takes no new item
// until its result is loaded into the output register, which waits while
// an earlier result is still to be taken. A logical capacity starting at 1
// doubles on insert into a full list and halves after a remove while
// count is below a quarter of it.
module indexed_list_insert_remove_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [6:0]  s_index,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_value,
    output logic [1:0]  m_status,
    output logic [6:0]  m_count,
    output logic [6:0]  m_capacity
);

    localparam int DEPTH   = ilir_pkg::DEPTH;
    localparam int VALUE_W = ilir_pkg::VALUE_W;
    localparam int CNT_W   = ilir_pkg::CNT_W;
    localparam int IDX_W   = ilir_pkg::IDX_W;

    ilir_pkg::state_t  state_reg, state_next;

    ilir_pkg::op_t      op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [VALUE_W-1:0] value_reg;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   cap_reg, cap_next;
    logic               sel_reg, sel_next;
    ilir_pkg::status_t  status_reg, status_next;

    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_read_value_reg;
    ilir_pkg::status_t  m_status_reg;
    logic [CNT_W-1:0]   m_count_reg;
    logic [CNT_W-1:0]   m_capacity_reg;

    logic               accept;
    logic               load_out;
    logic               exec;

    ilir_pkg::cell_cmd_t cmd;

    logic [VALUE_W-1:0] cell_data [DEPTH];
    logic [VALUE_W-1:0] cell_tap  [DEPTH];
    logic [VALUE_W-1:0] grp_reg   [ilir_pkg::GRP_CNT];
    logic [VALUE_W-1:0] grp_next  [ilir_pkg::GRP_CNT];
    logic [VALUE_W-1:0] tree_out;

    // decode of the request held in the execute state
    logic               in_range;
    logic               app_ok;
    logic               full;
    logic               do_ins;
    logic               do_rem;
    logic               do_wr;
    logic [CNT_W-1:0]   grown;
    logic [CNT_W-1:0]   rem_count;
    logic [CNT_W-1:0]   shrunk;

    assign accept   = s_valid && s_ready;
    assign exec     = (state_reg == ilir_pkg::ST_EXEC);
    assign in_range = (idx_reg < count_reg);
    assign app_ok   = (idx_reg <= count_reg);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign grown    = ((cap_reg << 1) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : (cap_reg << 1);
    assign rem_count = count_reg - CNT_W'(1);

    always_comb begin
        shrunk = cap_reg;
        for (int k = 0; k < ilir_pkg::SHRINK_STEPS; k++) begin
            if (({2'b00, rem_count} << 2) < {2'b00, shrunk} && shrunk > CNT_W'(1)) begin
                shrunk = shrunk >> 1;
            end
        end
    end

    always_comb begin
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        do_wr       = 1'b0;
        sel_next    = 1'b0;
        status_next = ilir_pkg::STAT_OK;
        case (op_reg)
            ilir_pkg::OP_REMOVE: begin
                if (in_range) begin
                    do_rem   = 1'b1;
                    sel_next = 1'b1;
                end else begin
                    status_next = ilir_pkg::STAT_RANGE;
                end
            end
            ilir_pkg::OP_GET: begin
                if (in_range) begin
                    sel_next = 1'b1;
                end else begin
                    status_next = ilir_pkg::STAT_RANGE;
                end
            end
            default: begin
                // set inside the list replaces; otherwise it acts as insert
                if (op_reg == ilir_pkg::OP_SET && in_range) begin
                    do_wr    = 1'b1;
                    sel_next = 1'b1;
                end else if (!app_ok) begin
                    status_next = ilir_pkg::STAT_RANGE;
                end else if (full) begin
                    status_next = ilir_pkg::STAT_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
        endcase

        count_next = count_reg;
        cap_next   = cap_reg;
        if (exec && do_ins) begin
            count_next = count_reg + CNT_W'(1);
            if (count_reg == cap_reg) begin
                cap_next = grown;
            end
        end else if (exec && do_rem) begin
            count_next = rem_count;
            cap_next   = shrunk;
        end
    end

    assign cmd.ins   = exec && do_ins;
    assign cmd.rem   = exec && do_rem;
    assign cmd.wr    = exec && do_wr;
    assign cmd.idx   = idx_reg;
    assign cmd.value = value_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VALUE_W-1:0] left_data;
        logic [VALUE_W-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        ilir_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .pos        (ilir_pkg::POS_W'(i)),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    // first level of the read tree, registered in the execute cycle
    always_comb begin
        for (int g = 0; g < ilir_pkg::GRP_CNT; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < ilir_pkg::GRP_SIZE; k++) begin
                if (g * ilir_pkg::GRP_SIZE + k < DEPTH) begin
                    grp_next[g] = grp_next[g] | cell_tap[g * ilir_pkg::GRP_SIZE + k];
                end
            end
        end
    end

    always_comb begin
        tree_out = '0;
        for (int g = 0; g < ilir_pkg::GRP_CNT; g++) begin
            tree_out = tree_out | grp_reg[g];
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        load_out     = 1'b0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ilir_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ilir_pkg::ST_EXEC;
                end
            end
            ilir_pkg::ST_EXEC: begin
                state_next = ilir_pkg::ST_RESP;
            end
            ilir_pkg::ST_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ilir_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ilir_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ilir_pkg::ST_IDLE;
            count_reg   <= '0;
            cap_reg     <= CNT_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= ilir_pkg::op_t'(s_op);
            idx_reg   <= s_index;
            value_reg <= s_value;
        end
        if (exec) begin
            sel_reg    <= sel_next;
            status_reg <= status_next;
            grp_reg    <= grp_next;
        end
        if (load_out) begin
            m_read_value_reg <= sel_reg ? tree_out : '0;
            m_status_reg     <= status_reg;
            m_count_reg      <= count_reg;
            m_capacity_reg   <= cap_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_count      = m_count_reg;
    assign m_capacity   = m_capacity_reg;

`ifndef SYNTHESIS
    a_cap_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(cap_reg))
        else $error("capacity is not a power of two");

    a_count_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_reg)
        else $error("count exceeds capacity");

    a_cap_le_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_reg <= CNT_W'(DEPTH))
        else $error("capacity exceeds depth");

    a_exec_to_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ilir_pkg::ST_EXEC |=> state_reg == ilir_pkg::ST_RESP)
        else $error("execute not followed by respond");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ilir_pkg::ST_EXEC |=> $stable(count_reg))
        else $error("count changed outside execute");
`endif

endmodule

// ===== rtl/ilir_cell.sv =====
`timescale 1ns / 1ps

module ilir_cell (
    input  logic                         aclk,
    input  ilir_pkg::cell_cmd_t          cmd,
    input  logic [ilir_pkg::POS_W-1:0]   pos,
    input  logic [ilir_pkg::VALUE_W-1:0] left_data,
    input  logic [ilir_pkg::VALUE_W-1:0] right_data,
    output logic [ilir_pkg::VALUE_W-1:0] data,
    output logic [ilir_pkg::VALUE_W-1:0] tap
);

    logic [ilir_pkg::VALUE_W-1:0] data_reg;
    logic [ilir_pkg::VALUE_W-1:0] data_next;
    logic [ilir_pkg::IDX_W-1:0]   pos_ext;
    logic                         at_idx;
    logic                         above_idx;

    assign pos_ext   = ilir_pkg::IDX_W'(pos);
    assign at_idx    = (pos_ext == cmd.idx);
    assign above_idx = (pos_ext > cmd.idx);

    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (above_idx) begin
                data_next = left_data;
            end else if (at_idx) begin
                data_next = cmd.value;
            end
        end else if (cmd.rem) begin
            // close the gap: take the upper neighbor
            if (above_idx || at_idx) begin
                data_next = right_data;
            end
        end else if (cmd.wr && at_idx) begin
            data_next = cmd.value;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = at_idx ? data_reg : '0;

endmodule

// ===== dv/ilir_result_check.sv =====
`timescale 1ns / 1ps

module ilir_result_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [6:0]  s_index,
    input  logic [31:0] s_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_read_value,
    input  logic [1:0]  m_status,
    input  logic [6:0]  m_count,
    input  logic [6:0]  m_capacity,
    output int          fail_count,
    output int          pending,
    output logic [6:0]  list_len
);

    typedef struct {
        logic [31:0]       read_value;
        ilir_pkg::status_t status;
        logic [6:0]        count;
        logic [6:0]        capacity;
    } list_result_t;

    logic [ilir_pkg::VALUE_W-1:0] shadow_list [ilir_pkg::DEPTH];
    int unsigned                  shadow_count;
    int unsigned                  shadow_cap;
    list_result_t                 owed_results [$];
    int                           mismatches;

    initial begin
        fail_count   = 0;
        pending      = 0;
        list_len     = '0;
        mismatches   = 0;
        shadow_count = 0;
        shadow_cap   = 1;
    end

    task automatic list_insert(input int unsigned pos, input logic [31:0] v,
                               output ilir_pkg::status_t st);
        if (pos > shadow_count) begin
            st = ilir_pkg::STAT_RANGE;
        end else if (shadow_count >= ilir_pkg::DEPTH) begin
            st = ilir_pkg::STAT_FULL;
        end else begin
            // grow before the shift, never past the physical depth
            if (shadow_count == shadow_cap) begin
                shadow_cap = (shadow_cap * 2 > ilir_pkg::DEPTH) ? ilir_pkg::DEPTH
                                                                : shadow_cap * 2;
            end
            for (int i = shadow_count; i > pos; i--) begin
                shadow_list[i] = shadow_list[i - 1];
            end
            shadow_list[pos] = v;
            shadow_count++;
            st = ilir_pkg::STAT_OK;
        end
    endtask

    task automatic apply_list_op(input ilir_pkg::op_t op, input int unsigned pos,
                                 input logic [31:0] v, output list_result_t res);
        ilir_pkg::status_t st;
        res.read_value = '0;
        case (op)
            ilir_pkg::OP_INSERT: begin
                list_insert(pos, v, st);
            end
            ilir_pkg::OP_REMOVE: begin
                if (pos >= shadow_count) begin
                    st = ilir_pkg::STAT_RANGE;
                end else begin
                    res.read_value = shadow_list[pos];
                    shadow_count--;
                    for (int i = pos; i < shadow_count; i++) begin
                        shadow_list[i] = shadow_list[i + 1];
                    end
                    while (shadow_count * 4 < shadow_cap && shadow_cap > 1) begin
                        shadow_cap = shadow_cap / 2;
                    end
                    st = ilir_pkg::STAT_OK;
                end
            end
            ilir_pkg::OP_GET: begin
                if (pos < shadow_count) begin
                    res.read_value = shadow_list[pos];
                    st = ilir_pkg::STAT_OK;
                end else begin
                    st = ilir_pkg::STAT_RANGE;
                end
            end
            default: begin
                // set at the end of the list acts as an insert there
                if (pos < shadow_count) begin
                    res.read_value   = shadow_list[pos];
                    shadow_list[pos] = v;
                    st = ilir_pkg::STAT_OK;
                end else begin
                    list_insert(pos, v, st);
                end
            end
        endcase
        res.status   = st;
        res.count    = 7'(shadow_count);
        res.capacity = 7'(shadow_cap);
    endtask

    task automatic compare_result(input list_result_t want);
        if (m_read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, m_read_value);
            mismatches++;
        end
        if (m_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_status);
            mismatches++;
        end
        if (m_count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, m_count);
            mismatches++;
        end
        if (m_capacity !== want.capacity) begin
            $error("capacity: expected %0d, got %0d", want.capacity, m_capacity);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            shadow_count = 0;
            shadow_cap   = 1;
            owed_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    compare_result(want);
                end
            end
            if (s_valid && s_ready) begin
                apply_list_op(ilir_pkg::op_t'(s_op), s_index, s_value, want);
                owed_results.push_back(want);
            end
        end
        fail_count <= mismatches;
        pending    <= owed_results.size();
        list_len   <= 7'(shadow_count);
    end

endmodule

// ===== dv/indexed_list_insert_remove_core_test.sv =====
`timescale 1ns / 1ps

module indexed_list_insert_remove_core_test;

    localparam int RANDOM_ITEMS = 1100;
    localparam int PHASE_LEN    = 150;
    localparam int CYCLE_LIMIT  = 100000;

    typedef enum int {
        PH_GROW,
        PH_SHRINK,
        PH_MIX
    } phase_t;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op         = '0;
    logic [6:0]  s_index      = '0;
    logic [31:0] s_value      = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [31:0] m_read_value;
    logic [1:0]  m_status;
    logic [6:0]  m_count;
    logic [6:0]  m_capacity;
    int          fail_count;
    int          pending;
    logic [6:0]  list_len;

    int idle_pct  = 18;
    int stall_pct = 18;
    int cycle_cnt = 0;

    indexed_list_insert_remove_core u_top (.*);

    ilir_result_check u_check (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL indexed_list_insert_remove_core");
            $finish;
        end
    end

    task automatic send_item(input ilir_pkg::op_t op, input logic [6:0] pos,
                             input logic [31:0] v);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_index <= pos;
        s_value <= v;
        @(posedge aclk);
        // hold until the transfer happens
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic ilir_pkg::op_t pick_op(input phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_GROW:   return (r < 60) ? ilir_pkg::OP_INSERT :
                              (r < 80) ? ilir_pkg::OP_SET :
                              (r < 90) ? ilir_pkg::OP_GET : ilir_pkg::OP_REMOVE;
            PH_SHRINK: return (r < 55) ? ilir_pkg::OP_REMOVE :
                              (r < 70) ? ilir_pkg::OP_GET :
                              (r < 85) ? ilir_pkg::OP_SET : ilir_pkg::OP_INSERT;
            default:   return ilir_pkg::op_t'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [6:0] pick_index(input ilir_pkg::op_t op, input int len);
        int r;
        int near_end;
        int top_idx;
        r        = $urandom_range(0, 99);
        near_end = len + $urandom_range(0, 2);
        top_idx  = (op == ilir_pkg::OP_INSERT || op == ilir_pkg::OP_SET) ? len :
                   (len == 0 ? 0 : len - 1);
        if (r < 8) begin
            return 7'($urandom_range(0, 127));
        end
        if (r < 14) begin
            return 7'((near_end > 127) ? 127 : near_end);
        end
        // favor appends so sets can grow the list too
        if (op == ilir_pkg::OP_SET && r < 40) begin
            return 7'(len);
        end
        return 7'($urandom_range(0, top_idx));
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end
        if (r < 10) begin
            return '1;
        end
        return $urandom;
    endfunction

    initial begin
        ilir_pkg::op_t op;
        phase_t        ph;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list: every access is out of range
        send_item(ilir_pkg::OP_GET,    7'd0, $urandom);
        send_item(ilir_pkg::OP_REMOVE, 7'd0, $urandom);
        send_item(ilir_pkg::OP_INSERT, 7'd1, $urandom);
        send_item(ilir_pkg::OP_SET,    7'd1, $urandom);
        // grow through capacities 1, 2, 4, 8
        send_item(ilir_pkg::OP_INSERT, 7'd0, 32'hFFFF_FFFF);
        send_item(ilir_pkg::OP_SET,    7'd1, 32'h0000_0000);
        send_item(ilir_pkg::OP_INSERT, 7'd1, 32'hA5A5_A5A5);
        send_item(ilir_pkg::OP_INSERT, 7'd0, 32'h5A5A_5A5A);
        send_item(ilir_pkg::OP_INSERT, 7'd4, 32'h1234_5678);
        send_item(ilir_pkg::OP_GET,    7'd4, $urandom);
        send_item(ilir_pkg::OP_GET,    7'd5, $urandom);
        send_item(ilir_pkg::OP_GET,    7'd127, $urandom);
        send_item(ilir_pkg::OP_INSERT, 7'd64, $urandom);
        send_item(ilir_pkg::OP_SET,    7'd2, 32'h8000_0001);
        send_item(ilir_pkg::OP_REMOVE, 7'd5, $urandom);
        // drain to empty so capacity halves back down to one
        send_item(ilir_pkg::OP_REMOVE, 7'd4, $urandom);
        send_item(ilir_pkg::OP_REMOVE, 7'd0, $urandom);
        send_item(ilir_pkg::OP_REMOVE, 7'd1, $urandom);
        send_item(ilir_pkg::OP_REMOVE, 7'd0, $urandom);
        send_item(ilir_pkg::OP_REMOVE, 7'd0, $urandom);
        send_item(ilir_pkg::OP_SET,    7'd0, 32'h7FFF_FFFF);

        ph = PH_GROW;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                ph        = phase_t'((n / PHASE_LEN) % 3);
                idle_pct  = (n / PHASE_LEN == 3) ? 0 : 18;
                stall_pct = idle_pct;
            end
            op = pick_op(ph);
            send_item(op, pick_index(op, list_len), pick_value());
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (fail_count == 0) begin
            $display("PASS indexed_list_insert_remove_core");
        end else begin
            $display("FAIL indexed_list_insert_remove_core");
        end
        $finish;
    end

endmodule
